FILE: rtl/uhkn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uhkn_pkg;

  // Register indexes on the configuration port
  localparam logic REG_MODE = 1'b0;

  // Mode register values
  localparam logic MODE_HANGUL = 1'b0;
  localparam logic MODE_KANA   = 1'b1;

  localparam logic [20:0] HANGUL_FIRST   = 21'h00AC00;
  localparam logic [20:0] HANGUL_LAST    = 21'h00D7A3;
  localparam logic [20:0] JAMO_INIT_BASE = 21'h001100;
  localparam logic [20:0] JAMO_MED_BASE  = 21'h001161;
  localparam logic [20:0] JAMO_FIN_BASE  = 21'h0011A8;
  localparam logic [20:0] KATA_FIRST     = 21'h0030A1;
  localparam logic [20:0] KATA_LAST      = 21'h0030F6;
  localparam logic [20:0] KATA_SHIFT     = 21'h000060;
  localparam logic [20:0] REPLACEMENT    = 21'h00FFFD;
  localparam logic [5:0]  CONT_MASK      = 6'h3F;

  localparam int unsigned MED_COUNT = 21;
  localparam int unsigned FIN_COUNT = 28;

  // Reciprocals for the constant divisions of the syllable index
  localparam logic [15:0] RECIP_FIN   = 16'd37450;  // 2^20 / 28, rounded up
  localparam logic [11:0] RECIP_MED   = 12'd3121;   // 2^16 / 21, rounded up

  localparam logic [3:0] MAX_BYTES = 4'd9;

  // One decoded code point on its way from the decoder to the encoder
  typedef struct packed {
    logic [20:0] cp;
    logic        mode;
    logic        last;
  } cp_item_t;

  typedef struct packed {
    logic full;
    logic avail;
  } q_stat_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } enc_t;

  function automatic enc_t utf8_enc(input logic [20:0] cp);
    enc_t e;
    e.b = '0;
    if (cp < 21'h80) begin
      e.b[0] = cp[7:0];
      e.len  = 3'd1;
    end else if (cp < 21'h800) begin
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
      e.len  = 3'd2;
    end else if (cp < 21'h10000) begin
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
      e.len  = 3'd3;
    end else begin
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
      e.len  = 3'd4;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/uhkn_front.sv
`timescale 1ns / 1ps
`default_nettype none

module uhkn_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               mode,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_last,
  input  wire uhkn_pkg::q_stat_t  q_stat,
  output logic                    push,
  output uhkn_pkg::cp_item_t      push_item
);

  logic [1:0]  bytes_left, bytes_left_next;
  logic [20:0] code_accum, code_accum_next;
  logic        accept;
  logic        have;
  logic [20:0] cp;
  logic [1:0]  left_dec;
  logic [20:0] accum_dec;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  always_comb begin
    have      = 1'b0;
    cp        = '0;
    left_dec  = bytes_left;
    accum_dec = code_accum;
    if (bytes_left != 2'd0) begin
      accum_dec = {code_accum[14:0], in_byte[5:0] & uhkn_pkg::CONT_MASK};
      left_dec  = bytes_left - 2'd1;
      if (left_dec == 2'd0) begin
        have = 1'b1;
        cp   = accum_dec;
      end
    end else begin
      case (in_byte) inside
        8'b0???????: begin
          have = 1'b1;
          cp   = {13'd0, in_byte};
        end
        8'b110?????: begin
          accum_dec = {16'd0, in_byte[4:0]};
          left_dec  = 2'd1;
        end
        8'b1110????: begin
          accum_dec = {17'd0, in_byte[3:0]};
          left_dec  = 2'd2;
        end
        8'b11110???: begin
          accum_dec = {18'd0, in_byte[2:0]};
          left_dec  = 2'd3;
        end
        default: begin
          have = 1'b1;
          cp   = uhkn_pkg::REPLACEMENT;
        end
      endcase
    end
    // flush a partial sequence at the end of the text
    if (in_last && !have) begin
      have = 1'b1;
      cp   = accum_dec;
    end
  end

  always_comb begin
    bytes_left_next = bytes_left;
    code_accum_next = code_accum;
    if (accept) begin
      if (in_last || left_dec == 2'd0) begin
        bytes_left_next = 2'd0;
        code_accum_next = '0;
      end else begin
        bytes_left_next = left_dec;
        code_accum_next = accum_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= 2'd0;
      code_accum <= '0;
    end else begin
      bytes_left <= bytes_left_next;
      code_accum <= code_accum_next;
    end
  end

  assign push           = accept && have;
  assign push_item.cp   = cp;
  assign push_item.mode = mode;
  assign push_item.last = in_last;

endmodule

`default_nettype wire

FILE: rtl/uhkn_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module uhkn_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire uhkn_pkg::cp_item_t  push_item,
  input  wire logic                pop,
  output uhkn_pkg::cp_item_t       head_item,
  output uhkn_pkg::q_stat_t        q_stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  uhkn_pkg::cp_item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_stat.full  = (count == CNT_W'(DEPTH));
  assign q_stat.avail = (count != '0);
  assign head_item    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/uhkn_back.sv
`timescale 1ns / 1ps
`default_nettype none

module uhkn_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire uhkn_pkg::q_stat_t   q_stat,
  input  wire uhkn_pkg::cp_item_t  head_item,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               out_byte,
  output logic                     out_run_last,
  output logic                     out_text_end
);

  // stage 1: registered queue head
  logic               s1_valid;
  uhkn_pkg::cp_item_t s1_item;

  // stage 2: classify, syllable index split by 28
  logic        s2_valid;
  logic        s2_hangul;
  logic [20:0] s2_cp;
  logic [8:0]  s2_q;
  logic [4:0]  s2_fin;
  logic        s2_last;

  // stage 3: initial index from the quotient
  logic        s3_valid;
  logic        s3_hangul;
  logic [20:0] s3_cp;
  logic [8:0]  s3_q;
  logic [4:0]  s3_ini;
  logic [4:0]  s3_fin;
  logic        s3_last;

  // output serialiser
  logic            ser_valid;
  logic [8:0][7:0] ser_buf;
  logic [3:0]      ser_cnt;
  logic [3:0]      ser_idx;
  logic            ser_last;

  logic s1_ready, s2_ready, s3_ready, ser_ready;
  logic out_fire, ser_done;

  assign out_fire  = ser_valid && !out_stall;
  assign ser_done  = out_fire && (ser_idx == ser_cnt - 4'd1);
  assign ser_ready = !ser_valid || ser_done;
  assign s3_ready  = !s3_valid || ser_ready;
  assign s2_ready  = !s2_valid || s3_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign pop       = q_stat.avail && s1_ready;

  // stage 2 logic
  logic        c_hangul, c_kana;
  logic [13:0] c_idx;
  logic [29:0] c_prod_q;
  logic [8:0]  c_q;
  logic [13:0] c_q28;

  always_comb begin
    c_hangul = (s1_item.mode == uhkn_pkg::MODE_HANGUL) &&
               (s1_item.cp >= uhkn_pkg::HANGUL_FIRST) &&
               (s1_item.cp <= uhkn_pkg::HANGUL_LAST);
    c_kana   = (s1_item.mode == uhkn_pkg::MODE_KANA) &&
               (s1_item.cp >= uhkn_pkg::KATA_FIRST) &&
               (s1_item.cp <= uhkn_pkg::KATA_LAST);
    c_idx    = 14'(s1_item.cp - uhkn_pkg::HANGUL_FIRST);
    c_prod_q = 30'(c_idx) * 30'(uhkn_pkg::RECIP_FIN);
    c_q      = c_prod_q[28:20];
    c_q28    = {c_q, 5'd0} - {3'd0, c_q, 2'd0};
  end

  // stage 3 logic
  logic [20:0] c_prod_i;
  assign c_prod_i = 21'(s2_q) * 21'(uhkn_pkg::RECIP_MED);

  // serialiser load logic
  logic [8:0]      c_ini21;
  logic [4:0]      c_med;
  uhkn_pkg::enc_t  e_ini, e_med, e_fin, e_one;
  logic [8:0][7:0] c_buf;
  logic [3:0]      c_cnt;

  always_comb begin
    c_ini21 = {s3_ini, 4'd0} + {2'd0, s3_ini, 2'd0} + {4'd0, s3_ini};
    c_med   = 5'(s3_q - c_ini21);
    e_ini   = uhkn_pkg::utf8_enc(uhkn_pkg::JAMO_INIT_BASE + 21'(s3_ini));
    e_med   = uhkn_pkg::utf8_enc(uhkn_pkg::JAMO_MED_BASE + 21'(c_med));
    e_fin   = uhkn_pkg::utf8_enc(uhkn_pkg::JAMO_FIN_BASE + 21'(s3_fin) - 21'd1);
    e_one   = uhkn_pkg::utf8_enc(s3_cp);
    c_buf   = '0;
    if (s3_hangul) begin
      c_buf[0] = e_ini.b[0];
      c_buf[1] = e_ini.b[1];
      c_buf[2] = e_ini.b[2];
      c_buf[3] = e_med.b[0];
      c_buf[4] = e_med.b[1];
      c_buf[5] = e_med.b[2];
      c_buf[6] = e_fin.b[0];
      c_buf[7] = e_fin.b[1];
      c_buf[8] = e_fin.b[2];
      c_cnt    = (s3_fin != 5'd0) ? uhkn_pkg::MAX_BYTES : 4'd6;
    end else begin
      c_buf[0] = e_one.b[0];
      c_buf[1] = e_one.b[1];
      c_buf[2] = e_one.b[2];
      c_buf[3] = e_one.b[3];
      c_cnt    = {1'b0, e_one.len};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      ser_valid <= 1'b0;
      ser_idx   <= '0;
    end else begin
      if (s1_ready) s1_valid <= q_stat.avail;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (ser_ready) begin
        ser_valid <= s3_valid;
        ser_idx   <= '0;
      end else if (out_fire) begin
        ser_idx <= ser_idx + 4'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_item <= head_item;
    end
    if (s1_valid && s2_ready) begin
      s2_hangul <= c_hangul;
      s2_cp     <= c_kana ? s1_item.cp - uhkn_pkg::KATA_SHIFT : s1_item.cp;
      s2_q      <= c_q;
      s2_fin    <= 5'(c_idx - c_q28);
      s2_last   <= s1_item.last;
    end
    if (s2_valid && s3_ready) begin
      s3_hangul <= s2_hangul;
      s3_cp     <= s2_cp;
      s3_q      <= s2_q;
      s3_ini    <= c_prod_i[20:16];
      s3_fin    <= s2_fin;
      s3_last   <= s2_last;
    end
    if (s3_valid && ser_ready) begin
      ser_buf  <= c_buf;
      ser_cnt  <= c_cnt;
      ser_last <= s3_last;
    end
  end

  assign out_valid    = ser_valid;
  assign out_byte     = ser_buf[ser_idx];
  assign out_run_last = (ser_idx == ser_cnt - 4'd1);
  assign out_text_end = out_run_last && ser_last;

endmodule

`default_nettype wire

FILE: rtl/utf8_hangul_kana_normalizer.sv
`timescale 1ns / 1ps
`default_nettype none

// UTF-8 normaliser, one byte in and one byte out per request. The front end
// decodes each input byte as it arrives (one byte every clock while the code
// point queue has room) and pushes every finished code point, with the mode
// and end-of-text flag it was completed under, into a QUEUE_DEPTH-entry queue.
// The back end pops code points, splits Hangul syllables into two or three
// conjoining jamo (mode 0) or lowers katakana to hiragana (mode 1), re-encodes
// them and sends one output byte every clock the output is not stalled. A
// code point expands to 1 to 4 bytes for plain text, 6 or 9 for a decomposed
// syllable; the output serialiser is what sets the long-run rate. A finished
// code point passes through the queue, the registered queue head, the classify
// and initial-index stages and the serialiser. Continuation bytes are not
// checked, invalid lead bytes become U+FFFD, and a sequence cut short by
// in_last is flushed as the bits gathered so far. The mode register sits at
// byte address 0 of the APB port and is sampled when each code point completes.

module utf8_hangul_kana_normalizer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input byte stream
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  // output byte stream
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_run_last,
  output logic             out_text_end
);

  logic mode;
  logic cfg_wr;

  // Register index is the word address; low address bits are ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == uhkn_pkg::REG_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= uhkn_pkg::MODE_HANGUL;
    end else if (cfg_wr) begin
      mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == uhkn_pkg::REG_MODE) begin
      prdata[0] = mode;
    end
  end

  uhkn_pkg::q_stat_t  q_stat;
  uhkn_pkg::cp_item_t push_item, head_item;
  logic               push, pop;

  // Decode the byte stream into code points
  uhkn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // Hold finished code points so either side can stall on its own
  uhkn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  // Transform, re-encode and serialise
  uhkn_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .head_item    (head_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_text_end (out_text_end)
  );

endmodule

`default_nettype wire
